// ===== src/pcss_pkg.sv =====
// ----------------------------------------------------------------------------
// pcss_pkg
// Types and constants shared by the charge slot selector modules.
// ----------------------------------------------------------------------------
package pcss_pkg;

   localparam int REPORTED_SLOTS = 4;
   localparam int PANEL_W        = 2;
   localparam int SLOT_W         = 2;
   localparam int VOLT_W         = 16;
   localparam int MASK_W         = 4;
   localparam int PANEL_CODES    = 4;

   localparam logic [VOLT_W-1:0] FULL_VOLTAGE_RESET = 16'd4200;

   typedef logic [VOLT_W-1:0]  volt_type;
   typedef logic [PANEL_W-1:0] panel_type;
   typedef logic [SLOT_W-1:0]  slot_type;
   typedef logic [MASK_W-1:0]  mask_type;

   typedef struct packed {
      panel_type panel;
      volt_type  voltage_0;
      volt_type  voltage_1;
      volt_type  voltage_2;
      volt_type  voltage_3;
      logic      end_of_scan;
   } req_payload_type;

   typedef struct packed {
      panel_type panel_out;
      logic      charging;
      slot_type  battery_slot;
      logic      changed;
      mask_type  change_mask;
   } rsp_payload_type;

   // per-slot compare results from one lane
   typedef struct packed {
      logic below;
      logic at_full;
   } lane_flags_type;

   // merged decision for the reporting panel
   typedef struct packed {
      logic     changed;
      logic     active;
      slot_type slot;
   } decision_type;

endpackage

// ===== src/pcss_stream_if.sv =====
// ----------------------------------------------------------------------------
// pcss_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface pcss_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== src/pcss_lane.sv =====
// ----------------------------------------------------------------------------
// pcss_lane
// One slot lane: compares the slot voltage against the full threshold.
// ----------------------------------------------------------------------------
module pcss_lane
   import pcss_pkg::*;
(
   input  volt_type       voltage,
   input  volt_type       full_voltage,
   output lane_flags_type flags
);

   always_comb begin
      flags.below   = voltage < full_voltage;
      flags.at_full = !(voltage < full_voltage);
   end

endmodule

// ===== src/pcss_merge.sv =====
// ----------------------------------------------------------------------------
// pcss_merge
// Combines lane results into the select or release decision for a panel.
// ----------------------------------------------------------------------------
module pcss_merge
   import pcss_pkg::*;
#(
   parameter int SLOTS_PER_PANEL = 4
) (
   input  volt_type [REPORTED_SLOTS-1:0]       voltages,
   input  lane_flags_type [REPORTED_SLOTS-1:0] flags,
   input  logic                                active,
   input  slot_type                            slot,
   output decision_type                        decision
);

   localparam int SEL_LANES = (SLOTS_PER_PANEL < REPORTED_SLOTS) ?
                              SLOTS_PER_PANEL : REPORTED_SLOTS;

   logic     found;
   volt_type best_volt;
   slot_type best_slot;

   // lowest voltage below threshold, lower slot wins on equal voltage
   always_comb begin
      found     = 1'b0;
      best_volt = '0;
      best_slot = '0;
      for (int j = 0; j < REPORTED_SLOTS; j++) begin
         if (j < SEL_LANES && flags[j].below && (!found || voltages[j] < best_volt)) begin
            found     = 1'b1;
            best_volt = voltages[j];
            best_slot = slot_type'(j);
         end
      end
   end

   always_comb begin
      if (!active) begin
         decision.changed = found;
         decision.active  = found;
         decision.slot    = found ? best_slot : '0;
      end else if (flags[slot].at_full) begin
         decision.changed = 1'b1;
         decision.active  = 1'b0;
         decision.slot    = '0;
      end else begin
         decision.changed = 1'b0;
         decision.active  = 1'b1;
         decision.slot    = slot;
      end
   end

endmodule

// ===== src/panel_charge_slot_selector_core.sv =====
// ----------------------------------------------------------------------------
// panel_charge_slot_selector_core
// Picks and releases the charging battery slot of each reporting panel.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one panel report: panel index, four slot voltages in mV
//   and an end-of-scan mark. rsp_chan returns one result item per report:
//   the panel, whether it charges, the slot, a change flag and, on the last
//   report of a scan, the mask of panels that changed during that scan.
//   csr_chan writes full_voltage; it is always ready and must be written
//   only while no report is in flight.
// Timing:
//   Each report yields one result item in the cycle after acceptance. Unless
//   rsp_chan stalls, a report is taken every cycle: four slot lanes compare in
//   parallel and the merge stage updates at most one assignment entry in the
//   same cycle, so the rate is one item per cycle, set by the output register.
// Reset:
//   All panels idle, scan mask clear, full_voltage back to 4200 mV.
// Backpressure:
//   While rsp_chan is stalled the held result stays put and req_chan is
//   taken only when the output register empties in the same cycle.
// ----------------------------------------------------------------------------
module panel_charge_slot_selector_core
   import pcss_pkg::*;
#(
   parameter int PANELS          = 4,
   parameter int SLOTS_PER_PANEL = 4
) (
   input logic clock,
   input logic reset,
   pcss_stream_if.sink   req_chan,
   pcss_stream_if.source rsp_chan,
   pcss_stream_if.sink   csr_chan
);

   // only panel codes below PANELS hold an assignment entry
   localparam int TABLE_DEPTH = (PANELS < PANEL_CODES) ? PANELS : PANEL_CODES;

   logic            active_ff [PANEL_CODES];
   slot_type        slot_ff   [PANEL_CODES];
   mask_type        scan_mask_ff, scan_mask_in;
   volt_type        full_voltage_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   volt_type [REPORTED_SLOTS-1:0]       voltages;
   lane_flags_type [REPORTED_SLOTS-1:0] flags;
   decision_type                        decision;
   logic                                accept;
   logic                                in_range;
   req_payload_type                     req;

   assign req      = req_chan.data;
   assign accept   = req_chan.valid && req_chan.ready;
   assign in_range = int'(req.panel) < TABLE_DEPTH;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   assign voltages = {req.voltage_3, req.voltage_2, req.voltage_1, req.voltage_0};

   for (genvar j = 0; j < REPORTED_SLOTS; j++) begin : g_lane
      pcss_lane u_lane (
         .voltage      (voltages[j]),
         .full_voltage (full_voltage_ff),
         .flags        (flags[j])
      );
   end

   pcss_merge #(
      .SLOTS_PER_PANEL (SLOTS_PER_PANEL)
   ) u_merge (
      .voltages (voltages),
      .flags    (flags),
      .active   (active_ff[req.panel]),
      .slot     (slot_ff[req.panel]),
      .decision (decision)
   );

   always_comb begin
      logic     chg;
      mask_type merged;
      chg    = in_range && decision.changed;
      merged = scan_mask_ff | (chg ? mask_type'(1) << req.panel : '0);

      rsp_data_in.panel_out    = req.panel;
      rsp_data_in.charging     = in_range && decision.active;
      rsp_data_in.battery_slot = (in_range && decision.active) ? decision.slot : '0;
      rsp_data_in.changed      = chg;
      rsp_data_in.change_mask  = req.end_of_scan ? merged : '0;
      scan_mask_in             = req.end_of_scan ? '0 : merged;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PANEL_CODES; p++) begin
            active_ff[p] <= 1'b0;
            slot_ff[p]   <= '0;
         end
         scan_mask_ff    <= '0;
         full_voltage_ff <= FULL_VOLTAGE_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            full_voltage_ff <= csr_chan.data;
         end
         if (accept) begin
            if (in_range) begin
               active_ff[req.panel] <= decision.active;
               slot_ff[req.panel]   <= decision.slot;
            end
            scan_mask_ff <= scan_mask_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_idle_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.charging |-> rsp_data_ff.battery_slot == '0)
      else $error("idle panel reports a slot");

   a_scan_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req.end_of_scan |=> scan_mask_ff == '0)
      else $error("scan mask not cleared at end of scan");

   a_change_in_mask: assert property (@(posedge clock) disable iff (reset)
      accept && !req.end_of_scan && rsp_data_in.changed |=> scan_mask_ff[$past(req.panel)])
      else $error("change not gathered into scan mask");

endmodule
